// ===== rtl/htswe_pkg.sv =====
`default_nettype none
// shared types and constants for the html tag strip / word extract unit
// no dependencies; imported by the controller, datapath and top level
package htswe_pkg;

	localparam int unsigned MAX_WORD_DEF = 64;

	localparam logic [7:0] CH_TAG_OPEN  = 8'h3C;
	localparam logic [7:0] CH_TAG_CLOSE = 8'h3E;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0   = 8'h30;
	localparam logic [7:0] CH_DIGIT_9   = 8'h39;
	localparam logic [7:0] CH_CASE_BIT  = 8'h20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SPACE,
		ST_EMIT,
		ST_END
	} htswe_state_t;

	typedef struct packed {
		logic take_in;
		logic check;
		logic clear_word;
		logic load_space;
		logic load_char;
		logic load_end;
		logic mark_emitted;
		logic finish_text;
	} htswe_cmd_t;

	typedef struct packed {
		logic in_flush;
		logic last_pending;
		logic emit_ok;
		logic emitted_any;
		logic char_final;
		logic out_free;
	} htswe_sts_t;

	function automatic logic is_alnum(input logic [7:0] c);
		return ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
			((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
			((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
	endfunction

endpackage
`default_nettype wire

// ===== rtl/htswe_ctrl.sv =====
`default_nettype none
// sequencing state machine: accept, flush check, space, char burst, end marker
// depends on htswe_pkg for state, command and status types
module htswe_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  htswe_pkg::htswe_sts_t sts,
	output htswe_pkg::htswe_cmd_t cmd
);
	import htswe_pkg::*;

	htswe_state_t state_q;
	htswe_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.in_flush) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.emit_ok) begin
					state_nxt = sts.emitted_any ? ST_SPACE : ST_EMIT;
				end else begin
					state_nxt = sts.last_pending ? ST_END : ST_IDLE;
				end
			end
			ST_SPACE: begin
				if (sts.out_free) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free && sts.char_final) state_nxt = ST_IDLE;
			end
			ST_END: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.take_in = in_valid;
			end
			ST_CHECK: begin
				cmd.check      = 1'b1;
				cmd.clear_word = !sts.emit_ok;
			end
			ST_SPACE: begin
				cmd.load_space = sts.out_free;
			end
			ST_EMIT: begin
				cmd.load_char = sts.out_free;
				if (sts.out_free && sts.char_final) begin
					cmd.clear_word   = 1'b1;
					cmd.finish_text  = sts.last_pending;
					cmd.mark_emitted = !sts.last_pending;
				end
			end
			ST_END: begin
				cmd.load_end    = sts.out_free;
				cmd.finish_text = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_space, cmd.load_char, cmd.load_end}))
		else $error("more than one output load in a cycle");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_in |-> (state_q == ST_IDLE))
		else $error("input taken outside idle");

	a_finish_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_text |-> (cmd.load_char || cmd.load_end))
		else $error("text finished without a final transaction");

endmodule
`default_nettype wire

// ===== rtl/htswe_dp.sv =====
`default_nettype none
// datapath: tag tracking, word buffer memory, trim positions, output register
// depends on htswe_pkg for command/status types and character constants
module htswe_dp #(
	parameter int unsigned MAX_WORD = htswe_pkg::MAX_WORD_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  [7:0]            in_byte,
	input  wire                   in_last,
	input  htswe_pkg::htswe_cmd_t cmd,
	output htswe_pkg::htswe_sts_t sts,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [7:0]            out_char,
	output logic [1:0]            out_user,
	output logic                  out_end
);
	import htswe_pkg::*;

	localparam int unsigned AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
	localparam int unsigned CW = $clog2(MAX_WORD + 1);

	logic [7:0]    mem [MAX_WORD];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] rd_addr;

	logic          inside_tag_q;
	logic          last_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] first_q;
	logic [AW-1:0] lastpos_q;
	logic          seen_q;
	logic          emitted_q;
	logic [AW-1:0] ptr_q;

	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic [1:0]    out_user_q;
	logic          out_end_q;

	logic          in_open;
	logic          in_space;
	logic          add_en;
	logic [AW-1:0] wr_pos;
	logic          in_alnum;
	logic          out_free;
	logic          char_final;
	logic [7:0]    emit_char;

	assign in_open  = (in_byte == CH_TAG_OPEN);
	assign in_space = (in_byte == CH_SPACE);
	assign in_alnum = is_alnum(in_byte);
	assign wr_pos   = count_q[AW-1:0];
	assign add_en   = cmd.take_in && !inside_tag_q && !in_open && !in_space &&
		(count_q < CW'(MAX_WORD));

	assign out_free   = !out_valid_q || out_ready;
	assign char_final = (ptr_q == lastpos_q);

	assign sts.in_flush     = in_last || (!inside_tag_q && (in_open || in_space));
	assign sts.last_pending = last_q;
	assign sts.emit_ok      = seen_q && (count_q < CW'(MAX_WORD));
	assign sts.emitted_any  = emitted_q;
	assign sts.char_final   = char_final;
	assign sts.out_free     = out_free;

	always_comb begin
		if (cmd.check) begin
			rd_addr = first_q;
		end else if (cmd.load_char && !char_final) begin
			rd_addr = ptr_q + AW'(1);
		end else begin
			rd_addr = ptr_q;
		end
	end

	always_comb begin
		emit_char = rd_data_q;
		if ((ptr_q == first_q) && (rd_data_q >= CH_UPPER_A) && (rd_data_q <= CH_UPPER_Z)) begin
			emit_char = rd_data_q | CH_CASE_BIT;
		end
	end

	always_ff @(posedge clk) begin
		if (add_en) begin
			mem[wr_pos] <= in_byte;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_tag_q <= 1'b0;
			last_q       <= 1'b0;
			count_q      <= '0;
			first_q      <= '0;
			lastpos_q    <= '0;
			seen_q       <= 1'b0;
			emitted_q    <= 1'b0;
			ptr_q        <= '0;
		end else begin
			if (cmd.take_in) begin
				last_q <= in_last;
				if (inside_tag_q) begin
					if (in_byte == CH_TAG_CLOSE) inside_tag_q <= 1'b0;
				end else if (in_open) begin
					inside_tag_q <= 1'b1;
				end
			end
			if (add_en) begin
				count_q <= count_q + CW'(1);
				if (in_alnum) begin
					if (!seen_q) first_q <= wr_pos;
					lastpos_q <= wr_pos;
					seen_q    <= 1'b1;
				end
			end
			if (cmd.check) begin
				ptr_q <= first_q;
			end else if (cmd.load_char && !char_final) begin
				ptr_q <= ptr_q + AW'(1);
			end
			if (cmd.clear_word) begin
				count_q   <= '0;
				first_q   <= '0;
				lastpos_q <= '0;
				seen_q    <= 1'b0;
			end
			if (cmd.mark_emitted) begin
				emitted_q <= 1'b1;
			end
			if (cmd.finish_text) begin
				emitted_q    <= 1'b0;
				inside_tag_q <= 1'b0;
			end
		end
	end

	// output register: user bit 0 is has_char, bit 1 is run_last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_space || cmd.load_char || cmd.load_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_space) begin
			out_char_q <= CH_SPACE;
			out_user_q <= 2'b01;
			out_end_q  <= 1'b0;
		end else if (cmd.load_char) begin
			out_char_q <= emit_char;
			out_user_q <= {char_final, 1'b1};
			out_end_q  <= char_final && last_q;
		end else if (cmd.load_end) begin
			out_char_q <= 8'h00;
			out_user_q <= 2'b10;
			out_end_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_user  = out_user_q;
	assign out_end   = out_end_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_WORD))
		else $error("word count past limit");

	a_trim_order: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> ((first_q <= lastpos_q) && (CW'(lastpos_q) < count_q)))
		else $error("trim positions out of order");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_char |-> ((ptr_q >= first_q) && (ptr_q <= lastpos_q)))
		else $error("emit pointer outside trimmed word");

endmodule
`default_nettype wire

// ===== rtl/html_tag_strip_word_extract_unit.sv =====
`default_nettype none
// html tag strip / word extract unit, top level
// a byte that does not end a word is taken while idle; a word end passes a check state,
// then an optional leading space and the emitted bytes, each held until the output is free,
// or a bare end marker; results come via a registered buffer read
// output register lets the next byte in while the last transaction waits
// arst_n clears tag, word and text state; the word buffer needs no clearing
module html_tag_strip_word_extract_unit #(
	parameter int unsigned MAX_WORD = htswe_pkg::MAX_WORD_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,   // in_byte
	input  wire        s_axis_tlast,   // in_last
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_char
	output logic [1:0] m_axis_tuser,   // has_char, run_last
	output logic       m_axis_tlast    // end_of_text
);
	import htswe_pkg::*;

	htswe_cmd_t cmd;
	htswe_sts_t sts;

	htswe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	htswe_dp #(
		.MAX_WORD (MAX_WORD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_end   (m_axis_tlast)
	);

endmodule
`default_nettype wire

// ===== sim/html_tag_strip_word_extract_unit_test.sv =====
`timescale 1ns / 1ps
// testbench for html_tag_strip_word_extract_unit: html text bytes in, words out
// depends on rtl/htswe_pkg.sv and rtl/html_tag_strip_word_extract_unit.sv
module html_tag_strip_word_extract_unit_test;
	import htswe_pkg::*;

	localparam int unsigned WORD_LIMIT = MAX_WORD_DEF;

	typedef struct packed {
		logic [7:0] ch;
		logic       has;
		logic       eot;
		logic       rlast;
	} text_out_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	// expected output transactions, oldest first
	text_out_t expected_q[$];
	text_out_t byte_run_q[$];
	logic [7:0] text_q[$];

	// shadow of the stripper state
	logic        in_tag;
	logic [7:0]  word_buf [0:63];
	int unsigned word_len;
	int unsigned first_pos;
	int unsigned last_pos;
	logic        have_alnum;
	logic        any_out;

	int  fail_count = 0;
	int  bytes_sent = 0;
	bit  send_idle = 1'b1;
	bit  recv_idle = 1'b1;

	html_tag_strip_word_extract_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit letter_or_digit(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function void word_clear();
		word_len = 0;
		first_pos = 0;
		last_pos = 0;
		have_alnum = 1'b0;
	endfunction

	function void word_flush();
		logic [7:0] c;
		int unsigned p;
		if (word_len > 0 && word_len < WORD_LIMIT && have_alnum) begin
			if (any_out)
				byte_run_q.push_back('{ch: CH_SPACE, has: 1'b1, eot: 1'b0, rlast: 1'b0});
			for (p = first_pos; p <= last_pos; p++) begin
				c = word_buf[p];
				if (p == first_pos && c >= CH_UPPER_A && c <= CH_UPPER_Z)
					c = c | CH_CASE_BIT;
				byte_run_q.push_back('{ch: c, has: 1'b1, eot: 1'b0, rlast: 1'b0});
			end
			any_out = 1'b1;
		end
		word_clear();
	endfunction

	function void strip_byte(logic [7:0] b, logic last);
		text_out_t tail;
		byte_run_q.delete();
		if (in_tag) begin
			if (b == CH_TAG_CLOSE)
				in_tag = 1'b0;
		end else if (b == CH_TAG_OPEN) begin
			word_flush();
			in_tag = 1'b1;
		end else if (b == CH_SPACE) begin
			word_flush();
		end else if (word_len < WORD_LIMIT) begin
			word_buf[word_len] = b;
			if (letter_or_digit(b)) begin
				if (!have_alnum)
					first_pos = word_len;
				last_pos = word_len;
				have_alnum = 1'b1;
			end
			word_len++;
		end
		if (last) begin
			word_flush();
			if (byte_run_q.size() == 0)
				byte_run_q.push_back('{ch: 8'h00, has: 1'b0, eot: 1'b0, rlast: 1'b0});
			tail = byte_run_q.pop_back();
			tail.eot = 1'b1;
			byte_run_q.push_back(tail);
			in_tag = 1'b0;
			any_out = 1'b0;
			word_clear();
		end
		if (byte_run_q.size() > 0) begin
			tail = byte_run_q.pop_back();
			tail.rlast = 1'b1;
			byte_run_q.push_back(tail);
		end
		foreach (byte_run_q[i])
			expected_q.push_back(byte_run_q[i]);
	endfunction

	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		gap = send_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready))
			@(posedge clk);
		strip_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_text(string s, logic last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], last_at_end && (i == s.len() - 1));
	endtask

	task automatic wait_results_done();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] word_char();
		logic [7:0] c;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7: c = 8'($urandom_range(8'h61, 8'h7A));
			8, 9, 10, 11:           c = 8'($urandom_range(8'h41, 8'h5A));
			12, 13, 14:             c = 8'($urandom_range(8'h30, 8'h39));
			default: begin
				do
					c = 8'($urandom_range(1, 255));
				while (c == CH_SPACE || c == CH_TAG_OPEN);
			end
		endcase
		return c;
	endfunction

	// builds one text of words, tags and spaces; some are cut off anywhere
	function void build_text(bit allow_long);
		int unsigned pieces;
		int unsigned n;
		logic [7:0] c;
		text_q.delete();
		pieces = $urandom_range(1, 12);
		repeat (pieces) begin
			case ($urandom_range(0, 5))
				0, 1, 2: begin
					if (allow_long && $urandom_range(0, 9) == 0)
						n = $urandom_range(WORD_LIMIT - 3, WORD_LIMIT + 3);
					else
						n = $urandom_range(1, 9);
					repeat (n) text_q.push_back(word_char());
				end
				3, 4: begin
					text_q.push_back(CH_TAG_OPEN);
					n = $urandom_range(0, 6);
					repeat (n) begin
						do
							c = 8'($urandom_range(1, 255));
						while (c == CH_TAG_CLOSE);
						text_q.push_back(c);
					end
					text_q.push_back(CH_TAG_CLOSE);
				end
				default: begin
					n = $urandom_range(1, 3);
					repeat (n) text_q.push_back(CH_SPACE);
				end
			endcase
		end
		if ($urandom_range(0, 2) == 0 && text_q.size() > 1) begin
			n = $urandom_range(1, text_q.size() - 1);
			while (text_q.size() > n)
				void'(text_q.pop_back());
		end
	endfunction

	task automatic send_random_texts(int unsigned target, bit allow_long, bit mid_pause);
		int unsigned stop_at;
		stop_at = bytes_sent + target;
		while (bytes_sent < stop_at) begin
			build_text(allow_long);
			foreach (text_q[i]) begin
				send_byte(text_q[i], i == text_q.size() - 1);
				if (mid_pause && $urandom_range(0, 39) == 0)
					wait_results_done();
			end
		end
	endtask

	task automatic test_directed();
		send_idle = 1'b1;
		recv_idle = 1'b1;
		send_byte(CH_SPACE, 1'b0);
		send_text("(Hello>, ", 1'b0);
		send_text("<a <i>", 1'b0);
		send_byte(8'h01, 1'b0);
		send_text("Z9", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_text("<x", 1'b1);
		send_text("!!", 1'b0);
		send_byte(CH_SPACE, 1'b1);
		send_text("Q", 1'b1);
		wait_results_done();
	endtask

	task automatic test_streaming();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		send_random_texts(150, 1'b1, 1'b0);
		wait_results_done();
	endtask

	task automatic test_random_gaps();
		send_idle = 1'b1;
		recv_idle = 1'b1;
		send_random_texts(200, 1'b1, 1'b1);
		wait_results_done();
	endtask

	task automatic test_slow_sink();
		send_idle = 1'b0;
		recv_idle = 1'b1;
		send_random_texts(100, 1'b1, 1'b0);
		wait_results_done();
	endtask

	task automatic test_noise();
		logic [7:0] b;
		send_idle = 1'b1;
		recv_idle = 1'b0;
		repeat (60) begin
			b = 8'($urandom_range(1, 255));
			send_byte(b, $urandom_range(0, 15) == 0);
		end
		send_byte(8'hA5, 1'b1);
		wait_results_done();
	endtask

	task automatic note_failure(string what, text_out_t want, text_out_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%s: expected ch=%02h has=%b eot=%b last=%b, got ch=%02h has=%b eot=%b last=%b",
				what, want.ch, want.has, want.eot, want.rlast,
				got.ch, got.has, got.eot, got.rlast);
	endtask

	always @(posedge clk) begin
		text_out_t got;
		text_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{ch: m_axis_tdata, has: m_axis_tuser[0], eot: m_axis_tlast,
				rlast: m_axis_tuser[1]};
			if (expected_q.size() == 0) begin
				note_failure("unexpected transaction", '0, got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want)
					note_failure("mismatch", want, got);
			end
		end
	end

	initial begin
		int gap;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			gap = recv_idle ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!(m_axis_tvalid && m_axis_tready))
				@(posedge clk);
		end
	end

	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		s_axis_tlast <= 1'b0;
		in_tag = 1'b0;
		any_out = 1'b0;
		word_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_streaming();
		test_random_gaps();
		test_slow_sink();
		test_noise();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
